[rtl/bcdec_pkg.sv]
// Shared types, codes and constant-divide helpers for the block decoder.
package bcdec_pkg;

  // Alpha mode codes; the unused code decodes as opaque.
  localparam logic [1:0] MODE_OPAQUE   = 2'd0;
  localparam logic [1:0] MODE_EXPLICIT = 2'd1;
  localparam logic [1:0] MODE_INTERP   = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ALPHA_MODE = 1'b0;
  localparam logic REG_PUNCH      = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Reciprocals for exact truncating division over the ranges used here.
  localparam logic [10:0] RECIP3 = 11'd683;   // x < 2048, shift 11
  localparam logic [11:0] RECIP7 = 12'd2341;  // x < 5461, shift 14
  localparam logic [10:0] RECIP5 = 11'd1639;  // x < 2730, shift 13

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Everything the texel serializer needs for one block.
  typedef struct packed {
    rgb_t [3:0]      color;
    logic            three;
    logic [7:0][7:0] level;
    logic [1:0]      mode;
    logic [31:0]     cidx;
    logic [63:0]     abits;
  } palette_t;

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e.r = {c[15:11], c[15:13]};
    e.g = {c[10:5], c[10:9]};
    e.b = {c[4:0], c[4:2]};
    return e;
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'(RECIP3);
    return p[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(RECIP7);
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(RECIP5);
    return p[20:13];
  endfunction

endpackage

[rtl/bcdec_palette.sv]
// Three-stage palette pipeline: capture, weighted sums, constant divides.
module bcdec_palette import bcdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] color_bits,
  input  logic [63:0] alpha_bits,
  input  logic [1:0]  alpha_mode,
  input  logic        punchthrough_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output palette_t    pal
);

  // stage 0: captured block and config
  logic        v0;
  logic [63:0] cbits0, abits0;
  logic [1:0]  mode0;
  logic        pt0;

  // stage 1: expanded endpoints and weighted sums
  logic             v1;
  rgb_t             e0_1, e1_1;
  logic [2:0][9:0]  sum2_1, sum3_1;
  logic [2:0][7:0]  half_1;
  logic             three1, gt1;
  logic [7:0]       a0_1, a1_1;
  logic [6:1][10:0] asum1;
  logic [1:0]       mode1;
  logic [31:0]      cidx1;
  logic [63:0]      abits1;

  // stage 2
  logic v2;

  logic r0, r1, r2;
  assign r2       = !v2 || out_ready;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign in_ready = r0;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= in_valid;
    end
    if (r0 && in_valid) begin
      cbits0 <= color_bits;
      abits0 <= alpha_bits;
      mode0  <= alpha_mode;
      pt0    <= punchthrough_enable;
    end
  end

  // stage 1 logic
  rgb_t             e0, e1;
  logic [2:0][7:0]  c0ch, c1ch;
  logic [2:0][9:0]  sum2, sum3;
  logic [2:0][7:0]  half;
  logic [8:0]       hsum;
  logic             three, gt;
  logic [7:0]       a0, a1;
  logic [6:1][10:0] asum;
  logic [2:0]       w0, w1;

  always_comb begin
    e0 = expand565(cbits0[15:0]);
    e1 = expand565(cbits0[31:16]);
    c0ch = {e0.r, e0.g, e0.b};
    c1ch = {e1.r, e1.g, e1.b};
    for (int ch = 0; ch < 3; ch++) begin
      sum2[ch] = {1'b0, c0ch[ch], 1'b0} + {2'b00, c1ch[ch]};
      sum3[ch] = {2'b00, c0ch[ch]} + {1'b0, c1ch[ch], 1'b0};
      hsum     = {1'b0, c0ch[ch]} + {1'b0, c1ch[ch]};
      half[ch] = hsum[8:1];
    end
    three = (mode0 != MODE_EXPLICIT) && (mode0 != MODE_INTERP) && pt0 &&
            (cbits0[15:0] <= cbits0[31:16]);
    a0 = abits0[7:0];
    a1 = abits0[15:8];
    gt = a0 > a1;
    for (int k = 1; k <= 6; k++) begin
      if (gt) begin
        w0 = 3'(7 - k);
        w1 = 3'(k);
      end else if (k < 5) begin
        w0 = 3'(5 - k);
        w1 = 3'(k);
      end else begin
        w0 = 3'd0;
        w1 = 3'd0;
      end
      asum[k] = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
    if (r1 && v0) begin
      e0_1   <= e0;
      e1_1   <= e1;
      sum2_1 <= sum2;
      sum3_1 <= sum3;
      half_1 <= half;
      three1 <= three;
      gt1    <= gt;
      a0_1   <= a0;
      a1_1   <= a1;
      asum1  <= asum;
      mode1  <= mode0;
      cidx1  <= cbits0[63:32];
      abits1 <= abits0;
    end
  end

  // stage 2 logic: divides by three, five and seven
  palette_t        pal_next;
  logic [2:0][7:0] p2, p3;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p2[ch] = three1 ? half_1[ch] : div3(sum2_1[ch]);
      p3[ch] = three1 ? 8'h00 : div3(sum3_1[ch]);
    end
    pal_next.color[0] = e0_1;
    pal_next.color[1] = e1_1;
    pal_next.color[2] = '{r: p2[2], g: p2[1], b: p2[0]};
    pal_next.color[3] = '{r: p3[2], g: p3[1], b: p3[0]};
    pal_next.three    = three1;
    pal_next.level[0] = a0_1;
    pal_next.level[1] = a1_1;
    for (int k = 1; k <= 6; k++) begin
      if (gt1) begin
        pal_next.level[k+1] = div7(asum1[k]);
      end else if (k < 5) begin
        pal_next.level[k+1] = div5(asum1[k]);
      end else if (k == 5) begin
        pal_next.level[k+1] = 8'h00;
      end else begin
        pal_next.level[k+1] = ALPHA_OPAQUE;
      end
    end
    pal_next.mode  = mode1;
    pal_next.cidx  = cidx1;
    pal_next.abits = abits1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      pal <= pal_next;
    end
  end

endmodule

[rtl/bcdec_serializer.sv]
// Texel serializer: holds one block's palette and emits 16 texels in order.
module bcdec_serializer import bcdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_ready,
  input  palette_t   pal,
  output logic       texel_strobe,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic [3:0] texel_index,
  output logic       last
);

  logic            active;
  logic [3:0]      count;
  rgb_t [3:0]      color;
  logic            three;
  logic [7:0][7:0] level;
  logic [1:0]      mode;
  logic [31:0]     cidx;
  logic [63:0]     nib;
  logic [47:0]     aidx;

  logic [1:0] ci;
  rgb_t       col;
  logic [7:0] alpha_next;

  assign load_ready = !active || (count == 4'hf);

  always_comb begin
    ci  = cidx[1:0];
    col = color[ci];
    case (mode)
      MODE_EXPLICIT: alpha_next = {nib[3:0], nib[3:0]};
      MODE_INTERP:   alpha_next = level[aidx[2:0]];
      default:       alpha_next = (three && ci == 2'd3) ? 8'h00 : ALPHA_OPAQUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      texel_strobe <= 1'b0;
      count        <= 4'd0;
    end else begin
      texel_strobe <= active;
      if (load_valid && load_ready) begin
        active <= 1'b1;
        count  <= 4'd0;
      end else if (active) begin
        count <= count + 4'd1;
        if (count == 4'hf) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      red         <= col.r;
      green       <= col.g;
      blue        <= col.b;
      alpha       <= alpha_next;
      texel_index <= count;
      last        <= (count == 4'hf);
    end
    if (load_valid && load_ready) begin
      color <= pal.color;
      three <= pal.three;
      level <= pal.level;
      mode  <= pal.mode;
      cidx  <= pal.cidx;
      nib   <= pal.abits;
      aidx  <= pal.abits[63:16];
    end else if (active) begin
      cidx <= {2'b00, cidx[31:2]};
      nib  <= {4'h0, nib[63:4]};
      aidx <= {3'b000, aidx[47:3]};
    end
  end

endmodule

[rtl/bc1_bc2_bc3_block_decoder.sv]
// Top level of the BC1/BC2/BC3 4x4 block decoder.
// The first texel of a block is strobed once its start has passed capture, sums,
// divides, serializer load and the output register, then one texel per cycle.
// The single-texel serializer sets the block rate; up to three further blocks
// queue in the palette pipeline meanwhile.
// Reset (rst, synchronous): clears valid bits, strobe and both config regs.
module bc1_bc2_bc3_block_decoder import bcdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // block input
  input  logic        start,
  output logic        busy,
  input  logic [63:0] color_bits,
  input  logic [63:0] alpha_bits,
  // config write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  // texel output, one item per strobe, no back-pressure
  output logic        texel_strobe,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [3:0]  texel_index,
  output logic        last
);

  logic [1:0] alpha_mode;
  logic       punchthrough_enable;

  // Config registers; the user must write them only while idle (the block does
  // not enforce this), and each block still snapshots them at capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode          <= MODE_OPAQUE;
      punchthrough_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA_MODE: alpha_mode          <= cfg_data[1:0];
        REG_PUNCH:      punchthrough_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic     in_ready;
  logic     pal_valid;
  logic     pal_ready;
  palette_t pal;

  assign busy = !in_ready;

  // Palette and alpha levels for a block, three register stages deep.
  bcdec_palette u_palette (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (start),
    .in_ready            (in_ready),
    .color_bits          (color_bits),
    .alpha_bits          (alpha_bits),
    .alpha_mode          (alpha_mode),
    .punchthrough_enable (punchthrough_enable),
    .out_valid           (pal_valid),
    .out_ready           (pal_ready),
    .pal                 (pal)
  );

  // Walks the 16 texels; takes the next block on its final texel so
  // blocks leave back to back.
  bcdec_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (pal_valid),
    .load_ready   (pal_ready),
    .pal          (pal),
    .texel_strobe (texel_strobe),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .texel_index  (texel_index),
    .last         (last)
  );

endmodule

[rtl/bcdec_checker.sv]
// Port-level checker for the block decoder, bound to the top level.
module bcdec_checker (
  input logic        clk,
  input logic        rst,
  input logic        texel_strobe,
  input logic [3:0]  texel_index,
  input logic        last
);

  // A block's texels leave in consecutive cycles.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    texel_strobe && !last |=> texel_strobe)
    else $error("texel burst broken");

  // Texel positions count up by one within a block.
  a_order: assert property (@(posedge clk) disable iff (rst)
    texel_strobe && !last |=> texel_index == $past(texel_index) + 4'd1)
    else $error("texel index out of order");

  // The last flag marks texel fifteen and nothing else.
  a_last: assert property (@(posedge clk) disable iff (rst)
    texel_strobe |-> (last == (texel_index == 4'hf)))
    else $error("last flag mismatch");

  // A block never starts in the middle: a nonzero index follows a strobe.
  a_start: assert property (@(posedge clk) disable iff (rst)
    texel_strobe && texel_index != 4'd0 |-> $past(texel_strobe))
    else $error("block started mid-sequence");

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_bcdec_checker (
  .clk          (clk),
  .rst          (rst),
  .texel_strobe (texel_strobe),
  .texel_index  (texel_index),
  .last         (last)
);

[tb/sv/tb_bc1_bc2_bc3_block_decoder.sv]
// Self-checking testbench for the BC1/BC2/BC3 4x4 block decoder.
`timescale 1ns / 1ps

module tb_bc1_bc2_bc3_block_decoder;
  import bcdec_pkg::*;

  // Code 3 of alpha_mode is unused by the format; the block treats it as opaque.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Texel i of a group of four picks palette entry i: 0,1,2,3 per byte.
  localparam logic [31:0] IDX_ALL = 32'hE4E4_E4E4;

  // Idle cycles after the last texel before a register write. The first
  // texel trails start through the pipeline; the wait covers anything still in flight.
  localparam int unsigned SETTLE_CYCLES = 8;

  // The slowest legal run stays well under this watchdog limit.
  localparam int unsigned CYCLE_LIMIT = 300000;

  // Work items for the driver: a block, a register write, or a pause that
  // holds the sender until every predicted texel has come out.
  typedef enum logic [1:0] {OP_BLOCK, OP_CFG, OP_PAUSE} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [63:0] cbits;
    logic [63:0] abits;
    logic        reg_idx;
    logic [1:0]  reg_val;
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] idx;
    logic       last;
  } texel_t;

  // Block ports; every input holds a known value from time zero.
  logic        clk;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        busy;
  logic [63:0] color_bits  = '0;
  logic [63:0] alpha_bits  = '0;
  logic        cfg_write   = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [1:0]  cfg_data    = '0;
  logic        texel_strobe;
  logic [7:0]  red, green, blue, alpha;
  logic [3:0]  texel_index;
  logic        last;

  // Stimulus still to drive, and texels predicted but not yet seen.
  op_t    ops_pending[$];
  texel_t texels_due[$];

  // Our copy of the two configuration registers (reset values).
  logic [1:0] mode_reg  = MODE_OPAQUE;
  logic       punch_reg = 1'b0;

  // Driver bookkeeping.
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  int unsigned idle_run   = 0;

  // Run statistics.
  int unsigned mismatches     = 0;
  int unsigned texels_checked = 0;
  int unsigned blocks_taken   = 0;
  int unsigned three_blocks   = 0;
  int unsigned reg_writes     = 0;
  int unsigned pauses_done    = 0;
  int unsigned blocks_in_mode[4];
  int unsigned cycle_count    = 0;

  bc1_bc2_bc3_block_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .color_bits   (color_bits),
    .alpha_bits   (alpha_bits),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .texel_strobe (texel_strobe),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .texel_index  (texel_index),
    .last         (last)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // RGB565 to 8:8:8 by replicating the top bits into the low bits.
  function automatic logic [23:0] widen565(input logic [15:0] c);
    logic [7:0] r8, g8, b8;
    r8 = {c[15:11], 3'b000} | {5'd0, c[15:13]};
    g8 = {c[10:5], 2'b00} | {6'd0, c[10:9]};
    b8 = {c[4:0], 3'b000} | {5'd0, c[4:2]};
    return {r8, g8, b8};
  endfunction

  // Decode one block under the current register copy and queue its 16 texels.
  function automatic void decode_block(input logic [63:0] cb, input logic [63:0] ab);
    logic [23:0] e0, e1;
    logic        three;
    int unsigned pal[4][4];
    int unsigned lvl[8];
    int unsigned v0, v1, a, ci, ch, k, i;
    texel_t      t;
    e0 = widen565(cb[15:0]);
    e1 = widen565(cb[31:16]);
    // Punch-through only in the colour-only modes (opaque or the spare code).
    three = (mode_reg != MODE_EXPLICIT) && (mode_reg != MODE_INTERP) && punch_reg &&
            (cb[15:0] <= cb[31:16]);
    for (ch = 0; ch < 3; ch++) begin
      v0 = e0[8*(2-ch) +: 8];
      v1 = e1[8*(2-ch) +: 8];
      pal[0][ch] = v0;
      pal[1][ch] = v1;
      if (three) begin
        pal[2][ch] = (v0 + v1) / 2;
        pal[3][ch] = 0;
      end else begin
        pal[2][ch] = (2 * v0 + v1) / 3;
        pal[3][ch] = (v0 + 2 * v1) / 3;
      end
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    pal[3][3] = three ? 0 : 255;

    // Eight-level alpha: sevenths when a0 > a1, else fifths plus 0 and 255.
    lvl[0] = ab[7:0];
    lvl[1] = ab[15:8];
    if (lvl[0] > lvl[1]) begin
      for (k = 1; k < 7; k++)
        lvl[k+1] = ((7 - k) * lvl[0] + k * lvl[1]) / 7;
    end else begin
      for (k = 1; k < 5; k++)
        lvl[k+1] = ((5 - k) * lvl[0] + k * lvl[1]) / 5;
      lvl[6] = 0;
      lvl[7] = 255;
    end

    for (i = 0; i < 16; i++) begin
      ci = cb[32 + 2*i +: 2];
      case (mode_reg)
        MODE_EXPLICIT: a = ab[4*i +: 4] * 17;
        MODE_INTERP:   a = lvl[ab[16 + 3*i +: 3]];
        default:       a = pal[ci][3];
      endcase
      t.red   = pal[ci][0][7:0];
      t.green = pal[ci][1][7:0];
      t.blue  = pal[ci][2][7:0];
      t.alpha = a[7:0];
      t.idx   = i[3:0];
      t.last  = (i == 15);
      texels_due.insert(texels_due.size(), t);
    end
    blocks_taken++;
    blocks_in_mode[mode_reg]++;
    if (three)
      three_blocks++;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  function automatic logic [63:0] color_word(input logic [15:0] c0, input logic [15:0] c1,
                                             input logic [31:0] sel);
    return {sel, c1, c0};
  endfunction

  // Two alpha endpoints with texel i using level i mod 8, so every level shows.
  function automatic logic [63:0] ramp_alpha(input logic [7:0] a0, input logic [7:0] a1);
    logic [47:0] sel;
    int unsigned i;
    for (i = 0; i < 16; i++)
      sel[3*i +: 3] = i % 8;
    return {sel, a1, a0};
  endfunction

  function automatic void add_block(input logic [63:0] cb, input logic [63:0] ab);
    op_t op;
    op.kind    = OP_BLOCK;
    op.cbits   = cb;
    op.abits   = ab;
    op.reg_idx = 1'b0;
    op.reg_val = '0;
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  function automatic void add_reg_write(input logic idx, input logic [1:0] val);
    op_t op;
    op.kind    = OP_CFG;
    op.cbits   = '0;
    op.abits   = '0;
    op.reg_idx = idx;
    op.reg_val = val;
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  function automatic void add_pause();
    op_t op;
    op.kind    = OP_PAUSE;
    op.cbits   = '0;
    op.abits   = '0;
    op.reg_idx = 1'b0;
    op.reg_val = '0;
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random block biased toward the interesting endpoint orderings.
  function automatic void add_random_block();
    logic [63:0] cb, ab;
    cb = rand64();
    ab = rand64();
    case ($urandom_range(0, 9))
      0, 1, 2: if (cb[15:0] > cb[31:16]) cb[31:0] = {cb[15:0], cb[31:16]};
      3:       cb[31:16] = cb[15:0];
      4:       cb[31:0] = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                           ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: if (ab[7:0] > ab[15:8]) ab[15:0] = {ab[7:0], ab[15:8]};
      3:       ab[15:8] = ab[7:0];
      4:       ab[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
      default: ;
    endcase
    add_block(cb, ab);
  endfunction

  // Mostly back-to-back or short gaps, a few long ones, and now and then a
  // burst with no gaps at all.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 25);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 78) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 17);
    return $urandom_range(20, 70);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: pulls ops from ops_pending. A block is taken on an edge where
  // start is high and busy is low; register writes and pauses only go out
  // once every predicted texel has been seen.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : driver
    op_t         head;
    logic        take, nx_start, nx_wr, nx_idx;
    logic [1:0]  nx_val;
    logic [63:0] nx_cb, nx_ab;
    nx_start = start;
    nx_wr    = 1'b0;
    nx_idx   = cfg_index;
    nx_val   = cfg_data;
    nx_cb    = color_bits;
    nx_ab    = alpha_bits;
    if (rst) begin
      nx_start = 1'b0;
      gap_left = 0;
      idle_run = 0;
    end else begin
      take = start && !busy;
      if (take) begin
        decode_block(color_bits, alpha_bits);
        nx_start = 1'b0;
        gap_left = next_gap();
      end else if (gap_left != 0 && !start) begin
        gap_left--;
      end

      // The write driven last edge lands at this one.
      if (cfg_write) begin
        if (cfg_index == REG_ALPHA_MODE)
          mode_reg = cfg_data;
        else
          punch_reg = cfg_data[0];
        reg_writes++;
      end

      if (texels_due.size() == 0 && !start && !cfg_write)
        idle_run++;
      else
        idle_run = 0;

      if (!nx_start && !cfg_write && gap_left == 0 && ops_pending.size() != 0) begin
        head = ops_pending[0];
        case (head.kind)
          OP_BLOCK: begin
            void'(ops_pending.pop_front());
            nx_start = 1'b1;
            nx_cb    = head.cbits;
            nx_ab    = head.abits;
          end
          OP_CFG: begin
            if (idle_run >= SETTLE_CYCLES) begin
              void'(ops_pending.pop_front());
              nx_wr    = 1'b1;
              nx_idx   = head.reg_idx;
              nx_val   = head.reg_val;
              idle_run = 0;
            end
          end
          OP_PAUSE: begin
            if (texels_due.size() == 0) begin
              void'(ops_pending.pop_front());
              pauses_done++;
            end
          end
          default: ;
        endcase
      end
    end
    start      <= nx_start;
    color_bits <= nx_cb;
    alpha_bits <= nx_ab;
    cfg_write  <= nx_wr;
    cfg_index  <= nx_idx;
    cfg_data   <= nx_val;
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed texel is checked against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    texel_t want;
    if (!rst && texel_strobe === 1'b1) begin
      if (texels_due.size() == 0) begin
        flag_mismatch($sformatf("texel %0d strobed with no block outstanding", texel_index));
      end else begin
        want = texels_due.pop_front();
        texels_checked++;
        if (red !== want.red || green !== want.green || blue !== want.blue ||
            alpha !== want.alpha || texel_index !== want.idx || last !== want.last) begin
          flag_mismatch($sformatf(
            "exp rgba %h %h %h %h idx %0d last %0b, got %h %h %h %h idx %0d last %0b",
            want.red, want.green, want.blue, want.alpha, want.idx, want.last,
            red, green, blue, alpha, texel_index, last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed blocks first, then random phases over all settings.
  // ---------------------------------------------------------------------
  initial begin : sequence_run
    int unsigned p, n, wait_cycles;
    logic [1:0]  mode_val;

    // Reset values: opaque, no punch-through.
    add_block('0, '0);
    add_block('1, '1);
    add_block(color_word(16'hF800, 16'h07E0, IDX_ALL), rand64());   // c0 > c1
    add_block(color_word(16'h001F, 16'hFFE0, IDX_ALL), rand64());   // c0 < c1, four colours

    // Punch-through on (upper data bit set, must be ignored).
    add_reg_write(REG_PUNCH, 2'b11);
    add_block(color_word(16'h0000, 16'hFFFF, IDX_ALL), rand64());   // three-colour
    add_block(color_word(16'h8410, 16'h8410, IDX_ALL), rand64());   // equal endpoints
    add_block(color_word(16'hFFFF, 16'h0000, IDX_ALL), rand64());   // back to four colours
    add_block(color_word(16'h1234, 16'hABCD, 32'hFFFF_FFFF), rand64()); // all transparent

    // Explicit alpha: punch-through must not apply.
    add_reg_write(REG_ALPHA_MODE, MODE_EXPLICIT);
    add_block(color_word(16'h0000, 16'hFFFF, IDX_ALL), 64'hFEDC_BA98_7654_3210);
    add_block(rand64(), '1);
    add_block(rand64(), '0);

    // Interpolated alpha: both level tables and the endpoint extremes.
    add_reg_write(REG_ALPHA_MODE, MODE_INTERP);
    add_block(rand64(), ramp_alpha(8'hF0, 8'h10));
    add_block(rand64(), ramp_alpha(8'h10, 8'hF0));
    add_block(rand64(), ramp_alpha(8'h80, 8'h80));
    add_block(rand64(), ramp_alpha(8'hFF, 8'h00));
    add_block(rand64(), ramp_alpha(8'h00, 8'hFF));
    add_block(color_word(16'h0000, 16'hFFFF, IDX_ALL), '1);

    // Unused mode code decodes as opaque, punch-through included.
    add_reg_write(REG_ALPHA_MODE, MODE_SPARE);
    add_block(color_word(16'h07E0, 16'hF800, IDX_ALL), rand64());
    add_block(color_word(16'hFFFF, 16'h0000, IDX_ALL), rand64());

    add_reg_write(REG_PUNCH, 2'b10);                                 // bit 0 clear: off
    add_block(color_word(16'h0000, 16'hFFFF, IDX_ALL), rand64());
    add_reg_write(REG_ALPHA_MODE, MODE_OPAQUE);
    add_pause();

    // Random part: twelve phases, each mode with punch-through off, then on, then off again.
    for (p = 0; p < 12; p++) begin
      case (p % 4)
        0:       mode_val = MODE_OPAQUE;
        1:       mode_val = MODE_EXPLICIT;
        2:       mode_val = MODE_INTERP;
        default: mode_val = MODE_SPARE;
      endcase
      add_reg_write(REG_ALPHA_MODE, mode_val);
      add_reg_write(REG_PUNCH, {1'($urandom), 1'((p / 4) % 2)});
      for (n = 0; n < 18; n++) begin
        add_random_block();
        if ($urandom_range(0, 19) == 0)
          add_pause();
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (ops_pending.size() != 0 || start || cfg_write)
      @(posedge clk);
    wait_cycles = 0;
    while (texels_due.size() != 0 && wait_cycles < 4000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);
    if (texels_due.size() != 0)
      flag_mismatch($sformatf("%0d texels never came out", texels_due.size()));

    $display("Checked %0d texels from %0d blocks; by alpha mode 0/1/2/3: %0d/%0d/%0d/%0d",
             texels_checked, blocks_taken, blocks_in_mode[0], blocks_in_mode[1],
             blocks_in_mode[2], blocks_in_mode[3]);
    $display("Three-colour blocks %0d, register writes %0d, drain pauses %0d",
             three_blocks, reg_writes, pauses_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bcdec_pkg.sv
rtl/bcdec_palette.sv
rtl/bcdec_serializer.sv
rtl/bc1_bc2_bc3_block_decoder.sv
rtl/bcdec_checker.sv
tb/sv/tb_bc1_bc2_bc3_block_decoder.sv
